### design/onewire_bus_master_defines.svh
// assertion macros for the one-wire bus master
// used by the queue and the bus sequencer, no other dependencies
`ifndef ONEWIRE_BUS_MASTER_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_DEFINES_SVH
`ifndef SYNTH
// checked only out of reset
`define OWBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define OWBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWBM_ASSERT(lbl, clk, rstn, prop, msg)
`define OWBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/owbm_pkg.sv
// shared types and constants of the one-wire bus master
// no dependencies
package owbm_pkg;

  // operation codes, equal to the command codes of the mode field
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;

  // line drive codes
  localparam logic [1:0] DRV_LOW  = 2'd0;
  localparam logic [1:0] DRV_HIGH = 2'd1;
  localparam logic [1:0] DRV_REL  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [2:0] REG_ONE_LOW       = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW      = 3'd3;
  localparam logic [2:0] REG_SLOT          = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;
  localparam logic [2:0] REG_SAMPLE_AT     = 3'd6;
  localparam logic [2:0] REG_BYTE_GAP      = 3'd7;

  localparam int CFG_DATA_W = 10;

  // register values after reset
  localparam logic [9:0] RST_RESET_LOW     = 10'd480;
  localparam logic [9:0] RST_RESET_RELEASE = 10'd480;
  localparam logic [7:0] RST_ONE_LOW       = 8'd10;
  localparam logic [7:0] RST_ZERO_LOW      = 8'd90;
  localparam logic [7:0] RST_SLOT          = 8'd92;
  localparam logic [7:0] RST_READ_LOW      = 8'd2;
  localparam logic [7:0] RST_SAMPLE_AT     = 8'd12;
  localparam logic [7:0] RST_BYTE_GAP      = 8'd20;

  // one classified tick as it sits in the queue
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] op;
    logic [7:0] data;
    logic       level;
  } tick_item_t;

endpackage

### design/onewire_bus_master.sv
// top level of the one-wire bus master
// depends on owbm_pkg, owbm_front, owbm_fifo and owbm_back
//
//  channel  direction  handshake                    payload
//  tick     in         in_valid_i / in_stall_o      mode_i, data_byte_i, line_level_i
//  result   out        out_valid_o / out_stall_i    line_drive_o, busy_res_o, done_res_o,
//                                                   read_value_o, status_o
//  config   in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// one item per cycle sustained while out_stall_i is low; each tick gives exactly one result item
// an accepted tick is written into the queue and then into the result register, also when the queue is empty
// the slot sequencer updates its state once per tick taken from the queue, which sets the rate
// reset clears the sequencer to idle, the queue to empty and the timing registers to defaults
// a stalled result holds in the output register; the queue absorbs ticks until it fills,
// after which in_stall_o rises
module onewire_bus_master #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      mode_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            line_level_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      line_drive_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [7:0]                      read_value_o,
  output logic                            status_o,
  // timing register writes
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_index_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // classified tick on its way into the queue
  owbm_pkg::tick_item_t push_item;
  // oldest tick waiting for the sequencer
  owbm_pkg::tick_item_t head_item;
  logic push, pop, full, empty;

  // front end: accept and decode the command
  owbm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .line_level_i (line_level_i),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  // decoupling queue, so the front keeps taking ticks while a result waits
  owbm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_item)
  );

  // back end: reset pulse, write and read slots, result register
  owbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .empty_i      (empty),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_drive_o (line_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

endmodule

### design/owbm_front.sv
// front end: takes ticks in and classifies the mode field
// depends on owbm_pkg
module owbm_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           mode_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 line_level_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output owbm_pkg::tick_item_t item_o
);

  logic is_cmd;

  always_comb begin
    is_cmd = mode_i inside {[owbm_pkg::OP_RESET : owbm_pkg::OP_WAIT]};
    item_o.is_cmd = is_cmd;
    // unknown modes behave as a plain tick
    item_o.op     = is_cmd ? mode_i : owbm_pkg::OP_IDLE;
    item_o.data   = data_byte_i;
    item_o.level  = line_level_i;
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

endmodule

### design/owbm_fifo.sv
// short queue between front end and sequencer
// depends on owbm_pkg and the assertion macro header
`include "onewire_bus_master_defines.svh"
module owbm_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  owbm_pkg::tick_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output owbm_pkg::tick_item_t head_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  owbm_pkg::tick_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // count is only meaningful once reset has been seen
  `OWBM_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || (count_q <= CNT_FULL), "queue count above depth")
  `OWBM_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && empty_o), "pop from empty queue")

endmodule

### design/owbm_back.sv
// bus sequencer: timing registers, slot state and the result register
// depends on owbm_pkg and the assertion macro header
`include "onewire_bus_master_defines.svh"
module owbm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                empty_i,
  input  owbm_pkg::tick_item_t                head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          line_drive_o,
  output logic                                busy_res_o,
  output logic                                done_res_o,
  output logic [7:0]                          read_value_o,
  output logic                                status_o
);

  // timing registers
  logic [9:0] reset_low_q, reset_release_q;
  logic [7:0] one_low_q, zero_low_q, slot_q, read_low_q, sample_at_q, byte_gap_q;

  // sequencer state
  logic [2:0] op_q, op_d;
  logic       ph_q, ph_d;
  logic [9:0] tc_q, tc_d;
  logic [2:0] bi_q, bi_d;
  logic [7:0] sb_q, sb_d;
  logic [7:0] last_rd_q, last_rd_d;

  // result register
  logic       out_valid_q;
  logic [1:0] drive_q, drive_d;
  logic       busy_q, busy_d, done_q, done_d, status_q, status_d;

  logic       fire, starting, finish;
  logic [2:0] op_cur;
  logic       ph;
  logic [9:0] tc;
  logic [2:0] bi;
  logic [7:0] sb;
  logic [7:0] slot_last, sample_pt, low_len;
  logic [9:0] reset_lim, release_lim;
  logic [2:0] pos;

  assign fire  = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q     <= owbm_pkg::RST_RESET_LOW;
      reset_release_q <= owbm_pkg::RST_RESET_RELEASE;
      one_low_q       <= owbm_pkg::RST_ONE_LOW;
      zero_low_q      <= owbm_pkg::RST_ZERO_LOW;
      slot_q          <= owbm_pkg::RST_SLOT;
      read_low_q      <= owbm_pkg::RST_READ_LOW;
      sample_at_q     <= owbm_pkg::RST_SAMPLE_AT;
      byte_gap_q      <= owbm_pkg::RST_BYTE_GAP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        owbm_pkg::REG_RESET_LOW:     reset_low_q     <= cfg_data_i;
        owbm_pkg::REG_RESET_RELEASE: reset_release_q <= cfg_data_i;
        owbm_pkg::REG_ONE_LOW:       one_low_q       <= cfg_data_i[7:0];
        owbm_pkg::REG_ZERO_LOW:      zero_low_q      <= cfg_data_i[7:0];
        owbm_pkg::REG_SLOT:          slot_q          <= cfg_data_i[7:0];
        owbm_pkg::REG_READ_LOW:      read_low_q      <= cfg_data_i[7:0];
        owbm_pkg::REG_SAMPLE_AT:     sample_at_q     <= cfg_data_i[7:0];
        owbm_pkg::REG_BYTE_GAP:      byte_gap_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // a zero length phase still takes one tick
    reset_lim   = (reset_low_q == '0) ? 10'd1 : reset_low_q;
    release_lim = (reset_release_q == '0) ? 10'd1 : reset_release_q;
    slot_last   = (slot_q < 8'd2) ? 8'd0 : slot_q - 8'd1;
    sample_pt   = (sample_at_q < slot_last) ? sample_at_q : slot_last;

    // command start folds into the first tick
    starting = (op_q == owbm_pkg::OP_IDLE) && head_i.is_cmd;
    status_d = (op_q != owbm_pkg::OP_IDLE) && head_i.is_cmd;
    op_cur   = starting ? head_i.op : op_q;
    ph       = starting ? 1'b0 : ph_q;
    tc       = starting ? '0 : tc_q;
    bi       = starting ? '0 : bi_q;
    sb       = starting ? ((head_i.op == owbm_pkg::OP_WRITE) ? head_i.data : 8'd0) : sb_q;

    finish    = 1'b0;
    op_d      = op_cur;
    ph_d      = ph;
    tc_d      = tc;
    bi_d      = bi;
    sb_d      = sb;
    last_rd_d = last_rd_q;
    drive_d   = owbm_pkg::DRV_HIGH;
    low_len   = sb[bi] ? one_low_q : zero_low_q;
    pos       = (op_cur == owbm_pkg::OP_WAIT) ? 3'd0 : bi;

    case (op_cur)
      owbm_pkg::OP_RESET: begin
        if (!ph) begin
          drive_d = owbm_pkg::DRV_LOW;
          if ({1'b0, tc} + 11'd1 >= {1'b0, reset_lim}) begin
            ph_d = 1'b1;
            tc_d = '0;
          end else begin
            tc_d = tc + 10'd1;
          end
        end else begin
          drive_d = owbm_pkg::DRV_REL;
          if ({1'b0, tc} + 11'd1 >= {1'b0, release_lim}) begin
            finish = 1'b1;
          end else begin
            tc_d = tc + 10'd1;
          end
        end
      end
      owbm_pkg::OP_WRITE: begin
        if (!ph) begin
          drive_d = (tc < {2'b00, low_len}) ? owbm_pkg::DRV_LOW : owbm_pkg::DRV_HIGH;
          if (tc >= {2'b00, slot_last}) begin
            tc_d = '0;
            if (bi == 3'd7) begin
              if (byte_gap_q == '0) begin
                finish = 1'b1;
              end else begin
                ph_d = 1'b1;
              end
            end else begin
              bi_d = bi + 3'd1;
            end
          end else begin
            tc_d = tc + 10'd1;
          end
        end else begin
          // high gap after the byte
          drive_d = owbm_pkg::DRV_HIGH;
          if ({1'b0, tc} + 11'd1 >= {3'b000, byte_gap_q}) begin
            finish = 1'b1;
          end else begin
            tc_d = tc + 10'd1;
          end
        end
      end
      owbm_pkg::OP_READ, owbm_pkg::OP_WAIT: begin
        drive_d = (tc < {2'b00, read_low_q}) ? owbm_pkg::DRV_LOW : owbm_pkg::DRV_REL;
        if ((tc == {2'b00, sample_pt}) && head_i.level) begin
          sb_d[pos] = 1'b1;
        end
        if (tc >= {2'b00, slot_last}) begin
          tc_d = '0;
          if (op_cur == owbm_pkg::OP_WAIT) begin
            if (sb_d[0]) begin
              finish = 1'b1;
            end else begin
              sb_d = '0;
            end
          end else if (bi == 3'd7) begin
            last_rd_d = sb_d;
            finish    = 1'b1;
          end else begin
            bi_d = bi + 3'd1;
          end
        end else begin
          tc_d = tc + 10'd1;
        end
      end
      default: ;
    endcase

    busy_d = (op_cur != owbm_pkg::OP_IDLE);
    done_d = finish;
    if (finish) begin
      op_d = owbm_pkg::OP_IDLE;
      ph_d = 1'b0;
      tc_d = '0;
      bi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= owbm_pkg::OP_IDLE;
      ph_q        <= 1'b0;
      tc_q        <= '0;
      bi_q        <= '0;
      sb_q        <= '0;
      last_rd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        op_q      <= op_d;
        ph_q      <= ph_d;
        tc_q      <= tc_d;
        bi_q      <= bi_d;
        sb_q      <= sb_d;
        last_rd_q <= last_rd_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      drive_q  <= drive_d;
      busy_q   <= busy_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_drive_o = drive_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign read_value_o = last_rd_q;
  assign status_o     = status_q;

  `OWBM_ASSERT(a_idle_clean, clk_i, rst_ni, (op_q == owbm_pkg::OP_IDLE) |-> (tc_q == '0 && bi_q == '0 && !ph_q), "idle with stale slot state")
  `OWBM_ASSERT(a_done_busy, clk_i, rst_ni, (out_valid_q && (done_q || status_q)) |-> busy_q, "done or reject outside an operation")
  `OWBM_ASSERT(a_done_to_idle, clk_i, rst_ni, (fire && done_d) |=> (op_q == owbm_pkg::OP_IDLE), "finished operation not idle")

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the one-wire bus master: directed ticks, then timing
// settings with random command sequences, checked against a behavioural model (typed rows against fixed results)
// depends on owbm_pkg and the onewire_bus_master rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // tick-only is the idle operation code; modes above wait are unused
  localparam logic [2:0] MODE_TICK  = owbm_pkg::OP_IDLE;
  localparam logic [2:0] MODE_SPARE = 3'd5;
  localparam logic [2:0] MODE_TOP   = 3'd7;

  typedef struct packed {
    logic [1:0] drive;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       status;
  } bus_result_t;

  // one row of the directed table; hold runs the operation out on the row's level
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data;
    logic        level;
    logic        hold;
    logic        typed;
    bus_result_t want;
  } tick_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_FOURTH, STALL_RUNS}
    stall_style_e;

  localparam bus_result_t IDLE_HIGH       = '{owbm_pkg::DRV_HIGH, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam bus_result_t IDLE_READ_FF    = '{owbm_pkg::DRV_HIGH, 1'b0, 1'b0, 8'hFF, 1'b0};
  localparam bus_result_t BUSY_LOW        = '{owbm_pkg::DRV_LOW, 1'b1, 1'b0, 8'h00, 1'b0};
  localparam bus_result_t BUSY_LOW_REJECT = '{owbm_pkg::DRV_LOW, 1'b1, 1'b0, 8'h00, 1'b1};
  localparam bus_result_t UNTYPED         = '0;

  localparam int N_ROWS = 20;
  localparam tick_row_t DIRECTED_ROWS [N_ROWS] = '{
    // idle after reset, line driven high whatever the level
    '{MODE_TICK,          8'h00, 1'b0, 1'b0, 1'b1, IDLE_HIGH},
    '{MODE_TICK,          8'hFF, 1'b1, 1'b0, 1'b1, IDLE_HIGH},
    // unused modes act as a plain tick
    '{MODE_SPARE,         8'hA5, 1'b0, 1'b0, 1'b1, IDLE_HIGH},
    '{MODE_TOP,           8'h5A, 1'b1, 1'b0, 1'b1, IDLE_HIGH},
    // bus reset starts at once, commands during it are rejected
    '{owbm_pkg::OP_RESET, 8'h00, 1'b0, 1'b0, 1'b1, BUSY_LOW},
    '{owbm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0, 1'b1, BUSY_LOW_REJECT},
    '{owbm_pkg::OP_READ,  8'h00, 1'b0, 1'b0, 1'b1, BUSY_LOW_REJECT},
    '{owbm_pkg::OP_WAIT,  8'h00, 1'b1, 1'b0, 1'b1, BUSY_LOW_REJECT},
    '{MODE_SPARE,         8'h00, 1'b0, 1'b1, 1'b1, BUSY_LOW},
    // full bytes
    '{owbm_pkg::OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, UNTYPED},
    '{owbm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, UNTYPED},
    '{owbm_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0, UNTYPED},
    '{owbm_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, UNTYPED},
    '{MODE_TICK,          8'h00, 1'b0, 1'b0, 1'b1, IDLE_READ_FF},
    '{owbm_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b0, UNTYPED},
    '{MODE_TICK,          8'h00, 1'b0, 1'b0, 1'b1, IDLE_HIGH},
    // wait for one leaves the read byte alone
    '{owbm_pkg::OP_WAIT,  8'h00, 1'b1, 1'b1, 1'b0, UNTYPED},
    '{MODE_TICK,          8'h00, 1'b0, 1'b0, 1'b1, IDLE_HIGH},
    // reset rejected inside a write-zero slot
    '{owbm_pkg::OP_WRITE, 8'h3C, 1'b0, 1'b0, 1'b1, BUSY_LOW},
    '{owbm_pkg::OP_RESET, 8'h00, 1'b1, 1'b1, 1'b1, BUSY_LOW_REJECT}
  };

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [2:0]                      mode_i       = MODE_TICK;
  logic [7:0]                      data_byte_i  = 8'h00;
  logic                            line_level_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [1:0]                      line_drive_o;
  logic                            busy_res_o;
  logic                            done_res_o;
  logic [7:0]                      read_value_o;
  logic                            status_o;
  logic                            cfg_we_i     = 1'b0;
  logic [2:0]                      cfg_index_i  = owbm_pkg::REG_RESET_LOW;
  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;

  // behavioural copy of the sequencer and its timing registers
  logic [9:0] timing_reg [8];
  logic [9:0] timing_plan [8];
  logic [2:0] bus_op    = owbm_pkg::OP_IDLE;
  logic       seq_phase = 1'b0;
  logic [9:0] seq_ticks = '0;
  logic [2:0] bit_pos   = '0;
  logic [7:0] shift_q   = '0;
  logic [7:0] last_rd   = '0;

  bus_result_t pending_results [$];

  int errors        = 0;
  int ticks_sent    = 0;
  int burst_left    = 0;
  int results_seen  = 0;
  int ops_done      = 0;
  int rejected_seen = 0;
  int settings_run  = 0;

  onewire_bus_master i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .line_level_i (line_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_drive_o (line_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // advances the model by one tick and gives the line drive and flags for it
  function automatic bus_result_t predict_bus_tick(logic [2:0] mode, logic [7:0] data,
                                                   logic level);
    bus_result_t r;
    logic is_cmd;
    int slot_end;
    int smp;
    int low_len;
    int span;
    r = '0;
    r.drive = owbm_pkg::DRV_HIGH;
    is_cmd = (mode >= owbm_pkg::OP_RESET) && (mode <= owbm_pkg::OP_WAIT);
    if (bus_op == owbm_pkg::OP_IDLE) begin
      if (is_cmd) begin
        bus_op    = mode;
        seq_phase = 1'b0;
        seq_ticks = '0;
        bit_pos   = '0;
        shift_q   = (mode == owbm_pkg::OP_WRITE) ? data : 8'h00;
      end
    end else if (is_cmd) begin
      r.status = 1'b1;
    end
    // slots of 0 or 1 tick collapse to a single tick
    slot_end = (timing_reg[owbm_pkg::REG_SLOT] < 2) ? 0 :
               int'(timing_reg[owbm_pkg::REG_SLOT]) - 1;
    if (bus_op != owbm_pkg::OP_IDLE) begin
      r.busy = 1'b1;
      case (bus_op)
        owbm_pkg::OP_RESET: begin
          // a zero-length reset phase still lasts one tick
          span = int'(seq_phase ? timing_reg[owbm_pkg::REG_RESET_RELEASE]
                                : timing_reg[owbm_pkg::REG_RESET_LOW]);
          if (span == 0) span = 1;
          r.drive = seq_phase ? owbm_pkg::DRV_REL : owbm_pkg::DRV_LOW;
          if (int'(seq_ticks) + 1 >= span) begin
            seq_ticks = '0;
            if (seq_phase) r.done = 1'b1;
            else seq_phase = 1'b1;
          end else begin
            seq_ticks++;
          end
        end
        owbm_pkg::OP_WRITE: begin
          if (!seq_phase) begin
            low_len = int'(shift_q[bit_pos] ? timing_reg[owbm_pkg::REG_ONE_LOW]
                                            : timing_reg[owbm_pkg::REG_ZERO_LOW]);
            r.drive = (int'(seq_ticks) < low_len) ? owbm_pkg::DRV_LOW : owbm_pkg::DRV_HIGH;
            if (int'(seq_ticks) >= slot_end) begin
              seq_ticks = '0;
              if (bit_pos == 3'd7) begin
                if (timing_reg[owbm_pkg::REG_BYTE_GAP] == '0) r.done = 1'b1;
                else seq_phase = 1'b1;
              end else begin
                bit_pos++;
              end
            end else begin
              seq_ticks++;
            end
          end else begin
            if (int'(seq_ticks) + 1 >= int'(timing_reg[owbm_pkg::REG_BYTE_GAP])) r.done = 1'b1;
            else seq_ticks++;
          end
        end
        default: begin
          // read slot: a late sample point falls back to the slot's last tick
          smp = (int'(timing_reg[owbm_pkg::REG_SAMPLE_AT]) < slot_end) ?
                int'(timing_reg[owbm_pkg::REG_SAMPLE_AT]) : slot_end;
          r.drive = (seq_ticks < timing_reg[owbm_pkg::REG_READ_LOW]) ?
                    owbm_pkg::DRV_LOW : owbm_pkg::DRV_REL;
          if (int'(seq_ticks) == smp && level) begin
            if (bus_op == owbm_pkg::OP_WAIT) shift_q[0] = 1'b1;
            else shift_q[bit_pos] = 1'b1;
          end
          if (int'(seq_ticks) >= slot_end) begin
            seq_ticks = '0;
            if (bus_op == owbm_pkg::OP_WAIT) begin
              if (shift_q[0]) r.done = 1'b1;
              else shift_q = '0;
            end else if (bit_pos == 3'd7) begin
              last_rd = shift_q;
              r.done  = 1'b1;
            end else begin
              bit_pos++;
            end
          end else begin
            seq_ticks++;
          end
        end
      endcase
      if (r.done) begin
        bus_op    = owbm_pkg::OP_IDLE;
        seq_phase = 1'b0;
        seq_ticks = '0;
        bit_pos   = '0;
      end
    end
    r.rd = last_rd;
    return r;
  endfunction

  // sender: bursts of random length with random gaps in front of them
  task automatic send_tick(logic [2:0] mode, logic [7:0] data, logic level,
                           logic typed = 1'b0, bus_result_t want = '0);
    bus_result_t predicted;
    int gap;
    predicted = predict_bus_tick(mode, data, level);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    data_byte_i  <= data;
    line_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold the sender off until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // finish any operation, go quiet, then write all eight timing registers
  task automatic load_timing();
    while (bus_op != owbm_pkg::OP_IDLE) send_tick(MODE_TICK, 8'($urandom), 1'($urandom));
    drain_results();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 3'(i);
      if (i == owbm_pkg::REG_RESET_LOW || i == owbm_pkg::REG_RESET_RELEASE) begin
        cfg_data_i    <= timing_plan[i];
        timing_reg[i] = timing_plan[i];
      end else begin
        // upper bits are junk for the byte-wide registers
        cfg_data_i    <= {2'($urandom), timing_plan[i][7:0]};
        timing_reg[i] = {2'b00, timing_plan[i][7:0]};
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // one command run to completion, with occasional commands thrown in while busy
  task automatic run_op(logic [2:0] cmd, int noise_pct);
    send_tick(cmd, 8'($urandom), 1'($urandom));
    while (bus_op != owbm_pkg::OP_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_tick(3'($urandom_range(owbm_pkg::OP_RESET, MODE_TOP)), 8'($urandom),
                  1'($urandom));
      else
        send_tick(MODE_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_phase(int budget);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < budget) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0)
            send_tick(MODE_TICK, 8'($urandom), 1'($urandom));
          else
            send_tick(3'($urandom_range(MODE_SPARE, MODE_TOP)), 8'($urandom), 1'($urandom));
        end
      end else begin
        run_op(3'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_WAIT)), 8);
      end
    end
  endtask

  // receiver stalls follow a style that is drawn again at random for each span
  initial begin
    stall_style_e style;
    int span;
    forever begin
      style = stall_style_e'($urandom_range(STALL_NONE, STALL_RUNS));
      span  = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        @(posedge clk_i);
        case (style)
          STALL_NONE:         out_stall_i <= 1'b0;
          STALL_LIGHT:        out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:        out_stall_i <= ($urandom_range(0, 9) < 7);
          STALL_EVERY_FOURTH: out_stall_i <= (i % 4 == 3);
          default:            out_stall_i <= ((i / 12) % 2 == 1);
        endcase
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    bus_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (line_drive_o !== want.drive) begin
          $error("line_drive: expected %0d, got %0d", want.drive, line_drive_o);
          errors++;
        end
        if (busy_res_o !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res_o);
          errors++;
        end
        if (done_res_o !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, done_res_o);
          errors++;
        end
        if (read_value_o !== want.rd) begin
          $error("read_value: expected 0x%02h, got 0x%02h", want.rd, read_value_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        results_seen++;
        if (want.done) ops_done++;
        if (want.status) rejected_seen++;
      end
    end
  end

  // hard stop well past the slowest correct run
  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int waited;
    timing_reg[owbm_pkg::REG_RESET_LOW]     = owbm_pkg::RST_RESET_LOW;
    timing_reg[owbm_pkg::REG_RESET_RELEASE] = owbm_pkg::RST_RESET_RELEASE;
    timing_reg[owbm_pkg::REG_ONE_LOW]       = {2'b00, owbm_pkg::RST_ONE_LOW};
    timing_reg[owbm_pkg::REG_ZERO_LOW]      = {2'b00, owbm_pkg::RST_ZERO_LOW};
    timing_reg[owbm_pkg::REG_SLOT]          = {2'b00, owbm_pkg::RST_SLOT};
    timing_reg[owbm_pkg::REG_READ_LOW]      = {2'b00, owbm_pkg::RST_READ_LOW};
    timing_reg[owbm_pkg::REG_SAMPLE_AT]     = {2'b00, owbm_pkg::RST_SAMPLE_AT};
    timing_reg[owbm_pkg::REG_BYTE_GAP]      = {2'b00, owbm_pkg::RST_BYTE_GAP};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // compact timing so whole bytes stay short; reset low long enough for the typed rows
    timing_plan = '{10'd6, 10'd4, 10'd1, 10'd5, 10'd8, 10'd1, 10'd3, 10'd2};
    load_timing();

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      send_tick(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].level,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      if (DIRECTED_ROWS[r].hold)
        while (bus_op != owbm_pkg::OP_IDLE)
          send_tick(MODE_TICK, 8'($urandom), DIRECTED_ROWS[r].level);
    end

    // everything at zero: one-tick reset phases and slots, no byte gap
    timing_plan = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
    load_timing();
    run_phase(60);

    // one-tick slots with nonzero low times
    timing_plan = '{10'd1, 10'd1, 10'd3, 10'd5, 10'd1, 10'd2, 10'd4, 10'd1};
    load_timing();
    run_phase(60);

    // low times past the end of the slot, late sample point
    timing_plan = '{10'd3, 10'd2, 10'd9, 10'd20, 10'd8, 10'd9, 10'd30, 10'd2};
    load_timing();
    run_phase(60);

    // wide values: reset low past eight bits, low times, sample point and gap at the top
    timing_plan = '{10'd260, 10'd1, 10'd255, 10'd255, 10'd4, 10'd255, 10'd255, 10'd255};
    load_timing();
    run_op(owbm_pkg::OP_RESET, 2);
    run_op(owbm_pkg::OP_WRITE, 2);
    run_op(owbm_pkg::OP_READ, 2);
    run_op(owbm_pkg::OP_WAIT, 2);

    // random small timings
    repeat (4) begin
      timing_plan[owbm_pkg::REG_RESET_LOW]     = 10'($urandom_range(0, 40));
      timing_plan[owbm_pkg::REG_RESET_RELEASE] = 10'($urandom_range(0, 40));
      timing_plan[owbm_pkg::REG_ONE_LOW]       = 10'($urandom_range(0, 12));
      timing_plan[owbm_pkg::REG_ZERO_LOW]      = 10'($urandom_range(0, 14));
      timing_plan[owbm_pkg::REG_SLOT]          = 10'($urandom_range(0, 14));
      timing_plan[owbm_pkg::REG_READ_LOW]      = 10'($urandom_range(0, 6));
      timing_plan[owbm_pkg::REG_SAMPLE_AT]     = 10'($urandom_range(0, 16));
      timing_plan[owbm_pkg::REG_BYTE_GAP]      = 10'($urandom_range(0, 10));
      load_timing();
      run_phase(40);
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      errors++;
    end
    $display("covered %0d ticks under %0d timing settings beyond reset", ticks_sent,
             settings_run);
    $display("checked %0d results: %0d operations completed, %0d commands rejected",
             results_seen, ops_done, rejected_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
